/* src/lkvft_pkg.sv */
// lkvft_pkg: types and codes shared by the feature table cells and top level
// no dependencies
package lkvft_pkg;

  // operation codes carried with each item
  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_DEFINE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FEATURE = 2'd1,
    ST_FULL       = 2'd2
  } status_t;

  // input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] creator_code;
    logic [15:0] feature_number;
    logic [31:0] write_value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
  } out_item_t;

  // request token that walks down the row of cells, one cell per cycle
  typedef struct packed {
    logic        vld;
    logic [1:0]  opcode;
    logic [31:0] creator;
    logic [15:0] number;
    logic [31:0] wval;
    logic        found;
    logic        appended;
    logic [31:0] rval;
  } tok_t;

endpackage

/* src/lkvft_cell.sv */
// lkvft_cell: one table entry plus one stage of the request token pipeline
// depends on lkvft_pkg
module lkvft_cell
  import lkvft_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_in,
  output tok_t             tok_out
);

  logic [31:0] creator_r;
  logic [15:0] number_r;
  logic [31:0] value_r;
  logic        locked_r;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic in_range;
  logic at_tail;
  logic key_hit;
  logic get_hit;
  logic set_hit;
  logic do_append;

  // entry is live below the fill count; the first free slot sits at the count
  assign in_range = CNT_W'(IDX) < count;
  assign at_tail  = CNT_W'(IDX) == count;

  // key compare, only the lowest matching entry acts
  assign key_hit = tok_in.vld && in_range && !tok_in.found &&
                   (creator_r == tok_in.creator) && (number_r == tok_in.number);
  assign get_hit = key_hit && (tok_in.opcode == OP_GET);
  assign set_hit = key_hit && (tok_in.opcode == OP_SET);

  // all live entries lie before the tail, so found is final by now
  assign do_append = tok_in.vld && at_tail &&
                     (((tok_in.opcode == OP_SET) && !tok_in.found) ||
                      (tok_in.opcode == OP_DEFINE));

  // token update
  always_comb begin
    tok_nxt = tok_in;
    if (get_hit || set_hit) begin
      tok_nxt.found = 1'b1;
    end
    if (get_hit) begin
      tok_nxt.rval = value_r;
    end
    if (do_append) begin
      tok_nxt.appended = 1'b1;
    end
  end

  // token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_append) begin
      creator_r <= tok_in.creator;
      number_r  <= tok_in.number;
      value_r   <= tok_in.wval;
      locked_r  <= (tok_in.opcode == OP_DEFINE);
    end else if (set_hit && !locked_r) begin
      value_r <= tok_in.wval;
    end
  end

  assign tok_out = tok_r;

endmodule

/* src/locked_key_value_feature_table.sv */
// locked_key_value_feature_table: associative feature table built as a row of cells
// result: registered at the output once the item has left the TABLE_DEPTH cells
// flow: the request passes one cell per cycle down the row of TABLE_DEPTH entries;
//   a new item is taken only once the last has left it and the skid stage is empty
// reset: the fill count clears to empty at once; entry contents stay undefined
//   until written, no clearing pass
module locked_key_value_feature_table
  import lkvft_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic             busy_r;
  logic             out_vld_r;
  out_item_t        out_r;
  logic             skid_vld_r;
  out_item_t        skid_r;

  logic      in_accept;
  logic      out_take;
  tok_t      chain [TABLE_DEPTH+1];
  tok_t      tok_exit;
  out_item_t res;

  // one item in flight at a time
  assign in_stall  = busy_r || skid_vld_r;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_vld_r && !out_stall;

  // token entering the first cell
  always_comb begin
    chain[0]          = '0;
    chain[0].vld      = in_accept;
    chain[0].opcode   = in_data.opcode;
    chain[0].creator  = in_data.creator_code;
    chain[0].number   = in_data.feature_number;
    chain[0].wval     = in_data.write_value;
  end

  // row of entry cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lkvft_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tok_exit = chain[TABLE_DEPTH];

  // result of the item leaving the row
  always_comb begin
    res.read_value = tok_exit.rval;
    unique case (tok_exit.opcode)
      OP_GET:    res.status = tok_exit.found ? ST_OK : ST_NO_FEATURE;
      OP_SET:    res.status = (tok_exit.found || tok_exit.appended) ? ST_OK : ST_FULL;
      OP_DEFINE: res.status = tok_exit.appended ? ST_OK : ST_FULL;
      default:   res.status = ST_OK;
    endcase
  end

  // fill count and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (tok_exit.vld) begin
        busy_r <= 1'b0;
      end
      if (tok_exit.vld) begin
        if (tok_exit.opcode == OP_CLEAR) begin
          count_r <= '0;
        end else if (tok_exit.appended) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (tok_exit.vld) begin
        if (!out_vld_r || out_take) begin
          out_vld_r <= 1'b1;
        end else begin
          skid_vld_r <= 1'b1;
        end
      end else if (skid_vld_r && (!out_vld_r || out_take)) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (tok_exit.vld) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (skid_vld_r && (!out_vld_r || out_take)) begin
      out_r <= skid_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // checks
  a_exit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit.vld |-> busy_r)
    else $error("item left the cell row with no item in flight");

  a_skid_no_exit: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !tok_exit.vld)
    else $error("item left the cell row while the skid stage was full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_exit.vld && (res.status == ST_FULL)) |-> (count_r == CNT_W'(TABLE_DEPTH)))
    else $error("table full reported below table depth");

endmodule
